// File: design/bsst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set span tracker package
// Shared widths, status codes and the neighbor lookup type for the tracker.
// ----------------------------------------------------------------------------
package bsst_pkg;

  localparam int unsigned DataW             = 32;
  localparam int unsigned CntW              = 9;
  localparam int unsigned IdxW              = 8;
  localparam int unsigned StatusW           = 2;
  localparam int unsigned ApbAddrW          = 3;
  localparam int unsigned ApbDataW          = 32;
  localparam int unsigned MaxEntriesDefault = 256;

  localparam logic [CntW-1:0]    CapacityReset = 9'd256;
  localparam logic [DataW-1:0]   SignBias      = 32'h8000_0000;

  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusRange = 2'd2;

  // Register index taken from the word address bit of paddr.
  localparam logic RegCapacity = 1'b0;

  typedef struct packed {
    logic             has_pred;
    logic             has_succ;
    logic [DataW-1:0] pred_key;
    logic [DataW-1:0] succ_key;
  } nbr_t;

endpackage

// File: design/bsst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted row cell
// Holds one biased key of the sorted row, compares it with a new key and
// either keeps it, takes the new key or takes the key of its left neighbor.
// ----------------------------------------------------------------------------
module bsst_cell (
  input  logic                        clk_i,
  input  logic                        ins_i,
  input  logic                        occ_i,
  input  logic [bsst_pkg::DataW-1:0]  new_key_i,
  input  logic [bsst_pkg::DataW-1:0]  left_key_i,
  input  logic                        left_le_i,
  input  logic                        right_le_i,
  output logic [bsst_pkg::DataW-1:0]  key_o,
  output logic                        le_o,
  output logic                        is_pred_o,
  output logic                        is_succ_o
);

  logic [bsst_pkg::DataW-1:0] key_q;
  logic [bsst_pkg::DataW-1:0] key_d;
  logic                       le;

  assign le = occ_i && (key_q <= new_key_i);

  always_comb begin
    if (le) begin
      key_d = key_q;
    end else if (left_le_i) begin
      key_d = new_key_i;
    end else begin
      key_d = left_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_i) begin
      key_q <= key_d;
    end
  end

  assign key_o     = key_q;
  assign le_o      = le;
  assign is_pred_o = le && !right_le_i;
  assign is_succ_o = !le && left_le_i && occ_i;

endmodule

// File: design/bsst_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted row
// A chain of cells that keeps the held keys in ascending order and finds the
// neighbors that a new key will have once it is inserted.
// ----------------------------------------------------------------------------
module bsst_row #(
  parameter int unsigned MAX_ENTRIES = bsst_pkg::MaxEntriesDefault
) (
  input  logic                        clk_i,
  input  logic                        ins_i,
  input  logic [bsst_pkg::CntW-1:0]   count_i,
  input  logic [bsst_pkg::DataW-1:0]  new_key_i,
  output bsst_pkg::nbr_t              nbr_o
);

  logic [bsst_pkg::DataW-1:0] key     [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]     le;
  logic [MAX_ENTRIES-1:0]     occ;
  logic [MAX_ENTRIES-1:0]     is_pred;
  logic [MAX_ENTRIES-1:0]     is_succ;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [bsst_pkg::DataW-1:0] left_key;
    logic                       left_le;
    logic                       right_le;

    assign occ[g] = (g < int'(count_i));

    if (g == 0) begin : g_first
      assign left_key = new_key_i;
      assign left_le  = 1'b1;
    end else begin : g_inner
      assign left_key = key[g-1];
      assign left_le  = le[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_last
      assign right_le = 1'b0;
    end else begin : g_body
      assign right_le = le[g+1];
    end

    bsst_cell u_cell (
      .clk_i      (clk_i),
      .ins_i      (ins_i),
      .occ_i      (occ[g]),
      .new_key_i  (new_key_i),
      .left_key_i (left_key),
      .left_le_i  (left_le),
      .right_le_i (right_le),
      .key_o      (key[g]),
      .le_o       (le[g]),
      .is_pred_o  (is_pred[g]),
      .is_succ_o  (is_succ[g])
    );
  end

  // Each flag vector has at most one bit set, so the neighbor keys are gathered by an OR tree.
  always_comb begin
    nbr_o          = '0;
    nbr_o.has_pred = |is_pred;
    nbr_o.has_succ = |is_succ;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      nbr_o.pred_key = nbr_o.pred_key | (key[i] & {bsst_pkg::DataW{is_pred[i]}});
      nbr_o.succ_key = nbr_o.succ_key | (key[i] & {bsst_pkg::DataW{is_succ[i]}});
    end
  end

endmodule

// File: design/bounded_set_span_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded set span tracker
// Holds up to a configured number of signed values and reports, with every
// result, the count and, with two or more held, the least neighbor gap and range.
// ----------------------------------------------------------------------------
// In the input transfer cycle of an item the key is inserted into the sorted
// cell row and the arrival memory is written or read; in the calculation
// state, once the output register is free, the new gaps to the sorted
// neighbors are formed and folded into the minimum. A new item is taken in
// the cycle after its predecessor's result is registered, so the block takes
// no new item while the last one is still being worked on.
// Values are kept in insertion order in a memory and as sign-biased keys in
// a row of MAX_ENTRIES compare cells; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module bounded_set_span_tracker #(
  parameter int unsigned MAX_ENTRIES = bsst_pkg::MaxEntriesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bsst_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bsst_pkg::ApbDataW-1:0]  pwdata,
  output logic [bsst_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic signed [bsst_pkg::DataW-1:0] value_i,
  input  logic [bsst_pkg::IdxW-1:0]      index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bsst_pkg::StatusW-1:0]   status_o,
  output logic [bsst_pkg::CntW-1:0]      count_o,
  output logic signed [bsst_pkg::DataW-1:0] read_value_o,
  output logic                           spans_valid_o,
  output logic [bsst_pkg::DataW-1:0]     shortest_span_o,
  output logic [bsst_pkg::DataW-1:0]     longest_span_o
);

  localparam int unsigned CntW     = bsst_pkg::CntW;
  localparam int unsigned DataW    = bsst_pkg::DataW;
  localparam int unsigned MemAw    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntMax   = (1 << CntW) - 1;
  localparam int unsigned CapLimit = (MAX_ENTRIES > CntMax) ? CntMax : MAX_ENTRIES;
  localparam logic [CntW-1:0] CapLimitW = CntW'(CapLimit);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]                  cap_q;
  logic [CntW-1:0]                  eff_cap;
  logic                             cfg_write;

  logic [DataW-1:0]                 mem [MAX_ENTRIES];
  logic [DataW-1:0]                 rdata_q;

  logic [CntW-1:0]                  count_q;
  logic [DataW-1:0]                 min_gap_q;
  logic [DataW-1:0]                 low_q;
  logic [DataW-1:0]                 high_q;

  logic                             accept;
  logic                             full;
  logic                             in_range;
  logic                             ins;
  logic [DataW-1:0]                 new_key;
  bsst_pkg::nbr_t                   nbr;

  bsst_pkg::nbr_t                   nbr_q;
  logic [DataW-1:0]                 key_q;
  logic                             ins_q;
  logic                             rd_ok_q;
  logic [bsst_pkg::StatusW-1:0]     status_q;

  logic                             commit;
  logic [DataW-1:0]                 gap_pred;
  logic [DataW-1:0]                 gap_succ;
  logic [DataW-1:0]                 min_a;
  logic [DataW-1:0]                 min_b;
  logic [DataW-1:0]                 min_new;
  logic                             spans_ok;

  logic                             out_valid_q;
  logic [bsst_pkg::StatusW-1:0]     out_status_q;
  logic [CntW-1:0]                  out_count_q;
  logic [DataW-1:0]                 out_read_q;
  logic                             out_spans_q;
  logic [DataW-1:0]                 out_short_q;
  logic [DataW-1:0]                 out_long_q;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == bsst_pkg::RegCapacity);
  assign prdata    = (paddr[2] == bsst_pkg::RegCapacity)
                     ? bsst_pkg::ApbDataW'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bsst_pkg::CapacityReset;
    end else if (cfg_write) begin
      cap_q <= pwdata[CntW-1:0];
    end
  end

  assign eff_cap = (cap_q > CapLimitW) ? CapLimitW : cap_q;

  // Input side.
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q >= eff_cap);
  assign in_range   = (CntW'(index_i) < count_q);
  assign ins        = accept && !mode_i && !full;
  assign new_key    = value_i ^ bsst_pkg::SignBias;

  bsst_row #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_row (
    .clk_i     (clk_i),
    .ins_i     (ins),
    .count_i   (count_q),
    .new_key_i (new_key),
    .nbr_o     (nbr)
  );

  always_ff @(posedge clk_i) begin
    if (ins) begin
      mem[MemAw'(count_q)] <= value_i;
    end
    if (accept) begin
      rdata_q <= mem[MemAw'(index_i)];
      nbr_q   <= nbr;
      key_q   <= new_key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_q    <= 1'b0;
      rd_ok_q  <= 1'b0;
      status_q <= bsst_pkg::StatusOk;
    end else if (accept) begin
      ins_q   <= ins;
      rd_ok_q <= mode_i && in_range;
      if (!mode_i) begin
        status_q <= full ? bsst_pkg::StatusFull : bsst_pkg::StatusOk;
      end else begin
        status_q <= in_range ? bsst_pkg::StatusOk : bsst_pkg::StatusRange;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      low_q   <= '0;
      high_q  <= '0;
    end else if (ins) begin
      count_q <= count_q + CntW'(1);
      if (count_q == '0) begin
        low_q  <= new_key;
        high_q <= new_key;
      end else begin
        if (new_key < low_q) begin
          low_q <= new_key;
        end
        if (new_key > high_q) begin
          high_q <= new_key;
        end
      end
    end
  end

  // Gap update and result formation.
  assign commit   = (state_q == S_CALC) && (!out_valid_q || out_ready_i);
  assign gap_pred = key_q - nbr_q.pred_key;
  assign gap_succ = nbr_q.succ_key - key_q;
  assign min_a    = (nbr_q.has_pred && (gap_pred < min_gap_q)) ? gap_pred : min_gap_q;
  assign min_b    = (nbr_q.has_succ && (gap_succ < min_a)) ? gap_succ : min_a;
  assign min_new  = ins_q ? min_b : min_gap_q;
  assign spans_ok = (count_q >= CntW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q <= '1;
    end else if (commit) begin
      min_gap_q <= min_new;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_status_q <= status_q;
      out_count_q  <= count_q;
      out_read_q   <= rd_ok_q ? rdata_q : '0;
      out_spans_q  <= spans_ok;
      out_short_q  <= spans_ok ? min_new : '0;
      out_long_q   <= spans_ok ? (high_q - low_q) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign count_o         = out_count_q;
  assign read_value_o    = out_read_q;
  assign spans_valid_o   = out_spans_q;
  assign shortest_span_o = out_short_q;
  assign longest_span_o  = out_long_q;

endmodule

// File: dv/bounded_set_span_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded set span tracker testbench
// Drives add and read transfers through the tracker, with random gaps on both
// handshakes, and checks each result against a behavioral model of the set or,
// for the typed opening rows, a fixed report. The capacity register is written
// over APB and read back between phases while the block is idle. The settings
// run from zero to the largest code; the run ends with the set filled to full depth.
// ----------------------------------------------------------------------------
module bounded_set_span_tracker_tb;

  localparam logic        ModeAdd     = 1'b0;
  localparam logic        ModeRead    = 1'b1;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned PhaseItems  = 206;
  localparam int unsigned CycleLimit  = 400_000;

  typedef struct packed {
    logic [bsst_pkg::StatusW-1:0] status;
    logic [bsst_pkg::CntW-1:0]    count;
    logic [bsst_pkg::DataW-1:0]   read_value;
    logic                         spans_valid;
    logic [bsst_pkg::DataW-1:0]   shortest;
    logic [bsst_pkg::DataW-1:0]   longest;
  } span_report_t;

  typedef struct packed {
    logic                       mode;
    logic [bsst_pkg::DataW-1:0] value;
    logic [bsst_pkg::IdxW-1:0]  index;
    logic                       typed;
    span_report_t               want;
  } stim_row_t;

  logic                               clk_i;
  logic                               rst_ni       = 1'b0;
  logic                               psel         = 1'b0;
  logic                               penable      = 1'b0;
  logic                               pwrite       = 1'b0;
  logic [bsst_pkg::ApbAddrW-1:0]      paddr        = '0;
  logic [bsst_pkg::ApbDataW-1:0]      pwdata       = '0;
  logic [bsst_pkg::ApbDataW-1:0]      prdata;
  logic                               pready;
  logic                               in_valid_i   = 1'b0;
  logic                               in_ready_o;
  logic                               mode_i       = ModeAdd;
  logic signed [bsst_pkg::DataW-1:0]  value_i      = '0;
  logic [bsst_pkg::IdxW-1:0]          index_i      = '0;
  logic                               out_valid_o;
  logic                               out_ready_i  = 1'b0;
  logic [bsst_pkg::StatusW-1:0]       status_o;
  logic [bsst_pkg::CntW-1:0]          count_o;
  logic signed [bsst_pkg::DataW-1:0]  read_value_o;
  logic                               spans_valid_o;
  logic [bsst_pkg::DataW-1:0]         shortest_span_o;
  logic [bsst_pkg::DataW-1:0]         longest_span_o;

  // Model of the held set: values in arrival order and sign-biased keys in
  // ascending order.
  logic [bsst_pkg::DataW-1:0] arrival_q   [bsst_pkg::MaxEntriesDefault];
  logic [bsst_pkg::DataW-1:0] sorted_keys [bsst_pkg::MaxEntriesDefault];
  int unsigned                held        = 0;
  logic [bsst_pkg::DataW-1:0] gap_min     = '1;
  logic [bsst_pkg::DataW-1:0] key_low     = '0;
  logic [bsst_pkg::DataW-1:0] key_high    = '0;
  logic [bsst_pkg::CntW-1:0]  cap_reg     = bsst_pkg::CapacityReset;

  span_report_t               pending_reports [$];
  stim_row_t                  opening_rows [$];
  logic [bsst_pkg::CntW-1:0]  phase_caps [PhaseCount] =
      '{9'd0, 9'd1, 9'd2, 9'd64, 9'd30, 9'd160, 9'd240, 9'd511};

  span_report_t     got;
  span_report_t     want;
  int unsigned      cycles      = 0;
  int unsigned      mismatches  = 0;
  int unsigned      sent        = 0;
  int unsigned      taken       = 0;
  int unsigned      full_seen   = 0;
  int unsigned      range_seen  = 0;
  bit               send_idle   = 1'b1;
  bit               recv_idle   = 1'b1;

  bounded_set_span_tracker u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .index_i        (index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .count_o        (count_o),
    .read_value_o   (read_value_o),
    .spans_valid_o  (spans_valid_o),
    .shortest_span_o(shortest_span_o),
    .longest_span_o (longest_span_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles,
               pending_reports.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic span_report_t track_item(logic mode,
                                              logic [bsst_pkg::DataW-1:0] value,
                                              logic [bsst_pkg::IdxW-1:0] index);
    span_report_t               r;
    logic [bsst_pkg::DataW-1:0] key;
    logic [bsst_pkg::DataW-1:0] gap;
    int unsigned                pos;
    int unsigned                limit;
    r = '0;
    r.status = bsst_pkg::StatusOk;
    limit = (cap_reg > bsst_pkg::MaxEntriesDefault) ? bsst_pkg::MaxEntriesDefault : cap_reg;
    if (mode == ModeAdd) begin
      if (held >= limit) begin
        r.status = bsst_pkg::StatusFull;
      end else begin
        key = value ^ bsst_pkg::SignBias;
        arrival_q[held] = value;
        pos = 0;
        while (pos < held && sorted_keys[pos] <= key) pos++;
        for (int k = held; k > pos; k--) sorted_keys[k] = sorted_keys[k-1];
        sorted_keys[pos] = key;
        if (pos > 0) begin
          gap = key - sorted_keys[pos-1];
          if (gap < gap_min) gap_min = gap;
        end
        if (pos < held) begin
          gap = sorted_keys[pos+1] - key;
          if (gap < gap_min) gap_min = gap;
        end
        if (held == 0) begin
          key_low  = key;
          key_high = key;
        end else begin
          if (key < key_low) key_low = key;
          if (key > key_high) key_high = key;
        end
        held++;
      end
    end else if (index >= held) begin
      r.status = bsst_pkg::StatusRange;
    end else begin
      r.read_value = arrival_q[index];
    end
    r.count       = bsst_pkg::CntW'(held);
    r.spans_valid = (held >= 2);
    if (r.spans_valid) begin
      r.shortest = gap_min;
      r.longest  = key_high - key_low;
    end
    return r;
  endfunction

  // Values close to one already held, or equal to it, keep the minimum gap
  // moving late in the run.
  function automatic logic [bsst_pkg::DataW-1:0] pick_value(bit near);
    logic [bsst_pkg::DataW-1:0] base;
    logic [bsst_pkg::DataW-1:0] offset;
    if (!near || held == 0) return $urandom;
    base = arrival_q[$urandom_range(0, held - 1)];
    if ($urandom_range(0, 7) == 0) return base;
    offset = $urandom_range(1, 1 << $urandom_range(0, 24));
    return $urandom_range(0, 1) ? base + offset : base - offset;
  endfunction

  function automatic void add_row(stim_row_t next_row);
    opening_rows = {opening_rows, next_row};
  endfunction

  task automatic send_item(logic mode, logic [bsst_pkg::DataW-1:0] value,
                           logic [bsst_pkg::IdxW-1:0] index,
                           bit typed, span_report_t typed_want);
    span_report_t predicted;
    int unsigned  gap;
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    value_i    <= value;
    index_i    <= index;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = track_item(mode, value, index);
    pending_reports = {pending_reports, typed ? typed_want : predicted};
    sent++;
    if (sent % 32 == 0) send_idle = ($urandom_range(0, 2) != 0);
    gap = send_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Lowers valid, waits for every outstanding result and lets the pipeline
  // settle before the port goes quiet.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [bsst_pkg::CntW-1:0] cap);
    logic [bsst_pkg::ApbDataW-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {bsst_pkg::RegCapacity, 2'b00};
    pwdata  <= bsst_pkg::ApbDataW'(cap);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cap_reg = cap;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    readback = prdata;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== bsst_pkg::ApbDataW'(cap)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Capacity read back as %h, expected %h.", readback,
                 bsst_pkg::ApbDataW'(cap));
    end
  endtask

  initial begin
    int unsigned  stall;
    wait (rst_ni);
    forever begin
      stall = recv_idle ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
      taken++;
      if (taken % 32 == 0) recv_idle = ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_o, count_o, read_value_o, spans_valid_o, shortest_span_o,
              longest_span_o};
      if (got.status == bsst_pkg::StatusFull) full_seen++;
      if (got.status == bsst_pkg::StatusRange) range_seen++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result with nothing outstanding: status %0d count %0d.",
                   got.status, got.count);
      end else begin
        want = pending_reports.pop_front();
        if (got.status !== want.status || got.count !== want.count ||
            got.read_value !== want.read_value || got.spans_valid !== want.spans_valid ||
            got.shortest !== want.shortest || got.longest !== want.longest) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at cycle %0d (got / expected):", cycles);
            $display("  status %0d / %0d, count %0d / %0d, read %h / %h",
                     got.status, want.status, got.count, want.count,
                     got.read_value, want.read_value);
            $display("  valid %0b / %0b, shortest %h / %h, longest %h / %h",
                     got.spans_valid, want.spans_valid, got.shortest, want.shortest,
                     got.longest, want.longest);
          end
        end
      end
    end
  end

  initial begin
    stim_row_t                  row;
    logic                       mode;
    logic [bsst_pkg::IdxW-1:0]  index;
    bit                         near;
    add_row('{ModeRead, 32'h0, 8'd0, 1'b1,
              '{bsst_pkg::StatusRange, 9'd0, 32'h0, 1'b0, 32'h0, 32'h0}});
    add_row('{ModeRead, 32'h0, 8'd255, 1'b1,
              '{bsst_pkg::StatusRange, 9'd0, 32'h0, 1'b0, 32'h0, 32'h0}});
    add_row('{ModeAdd, 32'h3000_0000, 8'd0, 1'b1,
              '{bsst_pkg::StatusOk, 9'd1, 32'h0, 1'b0, 32'h0, 32'h0}});
    add_row('{ModeRead, 32'h0, 8'd0, 1'b1,
              '{bsst_pkg::StatusOk, 9'd1, 32'h3000_0000, 1'b0, 32'h0, 32'h0}});
    add_row('{ModeRead, 32'h0, 8'd1, 1'b1,
              '{bsst_pkg::StatusRange, 9'd1, 32'h0, 1'b0, 32'h0, 32'h0}});
    add_row('{ModeAdd, 32'hD000_0000, 8'd0, 1'b1,
              '{bsst_pkg::StatusOk, 9'd2, 32'h0, 1'b1, 32'h6000_0000, 32'h6000_0000}});
    add_row('{ModeRead, 32'h0, 8'd1, 1'b1,
              '{bsst_pkg::StatusOk, 9'd2, 32'hD000_0000, 1'b1, 32'h6000_0000,
                32'h6000_0000}});
    add_row('{ModeRead, 32'h0, 8'd2, 1'b1,
              '{bsst_pkg::StatusRange, 9'd2, 32'h0, 1'b1, 32'h6000_0000,
                32'h6000_0000}});
    add_row('{ModeAdd, 32'h1234_5678, 8'd0, 1'b0, '0});
    add_row('{ModeAdd, 32'hEDCB_A987, 8'd0, 1'b0, '0});
    add_row('{ModeAdd, 32'h0000_0000, 8'd0, 1'b0, '0});
    add_row('{ModeAdd, 32'h5A5A_5A5A, 8'd0, 1'b0, '0});
    add_row('{ModeAdd, 32'hA5A5_A5A5, 8'd0, 1'b0, '0});
    add_row('{ModeRead, 32'hFFFF_FFFF, 8'd4, 1'b0, '0});
    add_row('{ModeRead, 32'h0, 8'd6, 1'b0, '0});
    add_row('{ModeRead, 32'h0, 8'd7, 1'b0, '0});
    add_row('{ModeRead, 32'h0, 8'hAA, 1'b0, '0});
    add_row('{ModeRead, 32'h0, 8'h55, 1'b0, '0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_rows[i]) begin
      row = opening_rows[i];
      send_item(row.mode, row.value, row.index, row.typed, row.want);
    end

    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      write_capacity(phase_caps[p]);
      @(posedge clk_i);
      // The last phase opens with the value extremes and a repeated value.
      if (p == PhaseCount - 1) begin
        send_item(ModeAdd, 32'h8000_0000, 8'd0, 1'b0, '0);
        send_item(ModeAdd, 32'h7FFF_FFFF, 8'd0, 1'b0, '0);
        send_item(ModeAdd, arrival_q[$urandom_range(0, held - 1)], 8'hFF, 1'b0, '0);
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == PhaseCount - 1)
          mode = ($urandom_range(0, 3) == 0) ? ModeRead : ModeAdd;
        else
          mode = $urandom_range(0, 1) ? ModeRead : ModeAdd;
        if (held > 0 && $urandom_range(0, 3) != 0)
          index = $urandom_range(0, held - 1);
        else
          index = $urandom_range(0, 255);
        near = (p >= PhaseCount - 2) && ($urandom_range(0, 3) == 0);
        send_item(mode, pick_value(near), index, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d transfers over %0d capacity settings; %0d values held at the end.",
             sent, PhaseCount + 1, held);
    $display("Saw %0d full and %0d out-of-range results; %0d mismatches.",
             full_seen, range_seen, mismatches);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
